// ----- src/lkv_pkg.sv -----
package lkv_pkg;

  // Fixed field widths of the item and the configuration register.
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  // Capacity after reset, and the value returned by a get that misses.
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_DATA = '1;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC,
    ST_RESP
  } lkv_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic exec;
    logic load_out;
  } lkv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic is_get;
    logic out_busy;
  } lkv_sts_t;

endpackage

// ----- src/lru_key_value_cache.sv -----
// A get is captured, swept, drained and executed, then its result beat is loaded once the result register is free.
// The next item is stalled until the current one is done, a get also waiting while a result beat is
// stalled; the search sweeps the key memory through its one port, one entry a cycle.
// Reset: control state, valid bits, recency ranks and the entry count are cleared and the
// capacity returns to 16; key and value memories are not cleared and need no clearing pass.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] data_in_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic signed [lkv_pkg::DATA_W-1:0] data_out_o,
  // Capacity register write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lkv_pkg::CFG_W-1:0]         cfg_data_i
);

  lkv_pkg::lkv_cmd_t cmd;
  lkv_pkg::lkv_sts_t sts;
  logic              cfg_we;

  // The capacity register takes a beat in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  lkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o),
    .data_out_o  (data_out_o)
  );

endmodule

// ----- src/lkv_ram.sv -----
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lkv_ctrl.sv -----
module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lkv_pkg::lkv_sts_t sts_i,
  output lkv_pkg::lkv_cmd_t cmd_o
);

  lkv_pkg::lkv_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lkv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lkv_pkg::ST_SCAN;
        end
      end
      lkv_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = lkv_pkg::ST_DRAIN;
        end
      end
      lkv_pkg::ST_DRAIN: begin
        state_d = lkv_pkg::ST_EXEC;
      end
      lkv_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_get ? lkv_pkg::ST_RESP : lkv_pkg::ST_IDLE;
      end
      lkv_pkg::ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = lkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/lkv_dp.sv -----
module lkv_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkv_pkg::lkv_cmd_t                 cmd_i,
  output lkv_pkg::lkv_sts_t                 sts_o,
  input  logic                              opcode_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0] data_in_i,
  input  logic                              cfg_we_i,
  input  logic [lkv_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic                              hit_o,
  output logic signed [lkv_pkg::DATA_W-1:0] data_out_o
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > lkv_pkg::CFG_W) ? CNT_W : lkv_pkg::CFG_W;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0]  CAP_MAX  = CMP_W'(ENTRIES);

  // Captured item.
  logic                      op_q;
  logic [lkv_pkg::DATA_W-1:0] key_q;
  logic [lkv_pkg::DATA_W-1:0] data_q;

  // Sweep counter and compare stage.
  logic [IDX_W-1:0] idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // Search results gathered during the sweep.
  logic              match_found_q, free_found_q, vict_found_q;
  logic [IDX_W-1:0]  match_idx_q, free_idx_q, vict_idx_q;
  logic [RANK_W-1:0] vict_rank_q;

  // Per-entry state.
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]  rank_q [ENTRIES];
  logic [RANK_W-1:0]  rank_d [ENTRIES];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [lkv_pkg::CFG_W-1:0] cap_q;

  // Result register.
  logic                      out_valid_q;
  logic                      hit_q;
  logic [lkv_pkg::DATA_W-1:0] dout_q;

  // Memory ports.
  logic [lkv_pkg::DATA_W-1:0] key_rd, val_rd;
  logic                       key_we, val_we, val_re;
  logic [IDX_W-1:0]           key_addr, val_addr;

  // Decision signals for the execute step.
  logic [CMP_W-1:0]  cap_lo, eff_cap;
  logic              cnt_full, ins_free, ins_do;
  logic [IDX_W-1:0]  slot;
  logic [RANK_W-1:0] promote_rank;
  logic              cmp_valid, cmp_match;
  logic [RANK_W-1:0] cmp_rank;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      key_q  <= $unsigned(key_i);
      data_q <= $unsigned(data_in_i);
    end
  end

  // Sweep address and the compare stage that follows the key memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      cmp_vld_q <= cmd_i.scan;
      cmp_idx_q <= idx_q;
    end
  end

  // Entry under compare: its valid bit, rank and key match.
  assign cmp_valid = valid_q[cmp_idx_q];
  assign cmp_rank  = rank_q[cmp_idx_q];
  assign cmp_match = cmp_valid && (key_rd == key_q);

  // Track the first matching entry, the first free slot and the least recent entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      vict_found_q  <= 1'b0;
      match_idx_q   <= '0;
      free_idx_q    <= '0;
      vict_idx_q    <= '0;
      vict_rank_q   <= '0;
    end else if (cmd_i.capture) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      vict_found_q  <= 1'b0;
    end else if (cmp_vld_q) begin
      if (cmp_match && !match_found_q) begin
        match_found_q <= 1'b1;
        match_idx_q   <= cmp_idx_q;
      end
      if (!cmp_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      if (cmp_valid && (!vict_found_q || cmp_rank > vict_rank_q)) begin
        vict_found_q <= 1'b1;
        vict_idx_q   <= cmp_idx_q;
        vict_rank_q  <= cmp_rank;
      end
    end
  end

  // Effective capacity: zero counts as one, and it never exceeds the store.
  assign cap_lo  = (cap_q == '0) ? CMP_W'(1) : CMP_W'(cap_q);
  assign eff_cap = (cap_lo > CAP_MAX) ? CAP_MAX : cap_lo;

  // Insert decision: a free slot while under capacity, otherwise the victim.
  assign cnt_full     = CMP_W'(cnt_q) >= eff_cap;
  assign ins_free     = !cnt_full && free_found_q;
  assign ins_do       = !match_found_q && (op_q == lkv_pkg::OP_SET) &&
                        (ins_free || vict_found_q);
  assign slot         = ins_free ? free_idx_q : vict_idx_q;
  assign promote_rank = rank_q[match_idx_q];

  // Rank, valid and count update in the execute step.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    cnt_d   = cnt_q;
    if (cmd_i.exec) begin
      if (match_found_q) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] < promote_rank) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[match_idx_q] = '0;
      end else if (ins_do) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] < RANK_MAX) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[slot]  = '0;
        valid_d[slot] = 1'b1;
        if (ins_free) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      rank_q  <= rank_d;
    end
  end

  // Key memory: swept during the search, written on insert.
  assign key_we   = cmd_i.exec && ins_do;
  assign key_addr = cmd_i.scan ? idx_q : slot;

  lkv_ram #(
    .WIDTH (lkv_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .re_i    (cmd_i.scan),
    .addr_i  (key_addr),
    .wdata_i (key_q),
    .rdata_o (key_rd)
  );

  // Value memory: read by a get, written by a set.
  assign val_we   = cmd_i.exec &&
                    ((match_found_q && (op_q == lkv_pkg::OP_SET)) || ins_do);
  assign val_re   = cmd_i.exec && (op_q == lkv_pkg::OP_GET);
  assign val_addr = match_found_q ? match_idx_q : slot;

  lkv_ram #(
    .WIDTH (lkv_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .re_i    (val_re),
    .addr_i  (val_addr),
    .wdata_i (data_q),
    .rdata_o (val_rd)
  );

  // Result register: holds a beat until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_q  <= match_found_q;
      dout_q <= match_found_q ? val_rd : lkv_pkg::MISS_DATA;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign data_out_o  = $signed(dout_q);

  // Status to the controller.
  assign sts_o.scan_last = (idx_q == LAST_IDX);
  assign sts_o.is_get    = (op_q == lkv_pkg::OP_GET);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

`ifndef SYNTHESIS
  // The entry count always equals the number of valid entries.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q))
    else $error("entry count differs from the number of valid entries");

  // A new result never overwrites a beat that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // An entry that was hit becomes the most recent one.
  a_hit_promoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && match_found_q |=> rank_q[match_idx_q] == '0)
    else $error("hit entry not made most recent");
`endif

endmodule
